// ----- design/jgr_pkg.sv -----
// ============================================================================
// jgr_pkg
// Shared types and constants of the joystick gesture recorder: field widths,
// register reset values, direction code bits, register indexes and the
// command/status bundles between controller and datapath.
// ============================================================================
package jgr_pkg;

  // Field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned DebW    = 8;
  localparam int unsigned IdleW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 32;  // x, y, button packed, padded to bytes
  localparam int unsigned OutDataW = 8;   // move code padded to a byte

  // Store depth default
  localparam int unsigned MaxMovesDefault = 32;

  // Register reset values
  localparam logic [SampleW-1:0] UpThrReset    = SampleW'(1000);
  localparam logic [SampleW-1:0] DownThrReset  = SampleW'(3000);
  localparam logic [SampleW-1:0] LeftThrReset  = SampleW'(3000);
  localparam logic [SampleW-1:0] RightThrReset = SampleW'(1000);
  localparam logic [DebW-1:0]    DebLimReset   = DebW'(10);
  localparam logic [IdleW-1:0]   IdleLimReset  = IdleW'(500);

  // Direction code bit positions
  localparam int unsigned BitUp    = 0;
  localparam int unsigned BitDown  = 1;
  localparam int unsigned BitLeft  = 2;
  localparam int unsigned BitRight = 3;
  localparam int unsigned BitBtn   = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_THR    = 3'd0,
    CFG_DOWN_THR  = 3'd1,
    CFG_LEFT_THR  = 3'd2,
    CFG_RIGHT_THR = 3'd3,
    CFG_DEB_LIM   = 3'd4,
    CFG_IDLE_LIM  = 3'd5
  } cfg_idx_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic tick;        // an input beat is accepted this cycle
    logic rd_issue;    // read the store at the readout index
    logic rd_advance;  // step the readout index
    logic rd_finish;   // readout done: clear count and index
  } jgr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic timeout;     // the current beat ends the gesture
    logic has_moves;   // the store holds at least one move
    logic rd_last;     // readout index points at the newest move
  } jgr_status_t;

endpackage

// ----- design/jgr_ram.sv -----
// ============================================================================
// jgr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module jgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/jgr_datapath.sv -----
// ============================================================================
// jgr_datapath
// Configuration registers, direction classifier, debounce and idle counters,
// move store and readout index.
// ============================================================================
module jgr_datapath import jgr_pkg::*; #(
  parameter int unsigned MaxMoves = MaxMovesDefault,
  localparam int unsigned CntW  = $clog2(MaxMoves + 1),
  localparam int unsigned AddrW = (MaxMoves > 1) ? $clog2(MaxMoves) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // beat payload
  input  logic [SampleW-1:0]  x_sample_i,
  input  logic [SampleW-1:0]  y_sample_i,
  input  logic                button_i,
  // control
  input  jgr_cmd_t            cmd_i,
  output jgr_status_t         status_o,
  // result payload
  output logic [CodeW-1:0]    move_code_o,
  output logic                last_move_o
);

  logic [SampleW-1:0] up_thr_q, down_thr_q, left_thr_q, right_thr_q;
  logic [DebW-1:0]    deb_lim_q;
  logic [IdleW-1:0]   idle_lim_q;

  logic [CntW-1:0]    count_q, count_d;
  logic [CodeW-1:0]   last_rd_q, last_rd_d;
  logic [CodeW-1:0]   newest_q, newest_d;
  logic [DebW-1:0]    stable_q, stable_d;
  logic [IdleW-1:0]   idle_q, idle_d;
  logic [AddrW-1:0]   rd_idx_q, rd_idx_d;

  logic [CodeW-1:0]   code;
  logic               full, differ, accept, append, neutral, evaluate;
  logic [IdleW-1:0]   idle_next;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_thr_q    <= UpThrReset;
      down_thr_q  <= DownThrReset;
      left_thr_q  <= LeftThrReset;
      right_thr_q <= RightThrReset;
      deb_lim_q   <= DebLimReset;
      idle_lim_q  <= IdleLimReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UP_THR:    up_thr_q    <= cfg_data_i[SampleW-1:0];
        CFG_DOWN_THR:  down_thr_q  <= cfg_data_i[SampleW-1:0];
        CFG_LEFT_THR:  left_thr_q  <= cfg_data_i[SampleW-1:0];
        CFG_RIGHT_THR: right_thr_q <= cfg_data_i[SampleW-1:0];
        CFG_DEB_LIM:   deb_lim_q   <= cfg_data_i[DebW-1:0];
        CFG_IDLE_LIM:  idle_lim_q  <= cfg_data_i[IdleW-1:0];
        default: ;
      endcase
    end
  end

  // Direction classifier; a full store reads as neutral
  assign full = (count_q == CntW'(MaxMoves));

  always_comb begin
    code = '0;
    if (!full) begin
      if (y_sample_i < up_thr_q) begin
        code[BitUp] = 1'b1;
      end else if (y_sample_i > down_thr_q) begin
        code[BitDown] = 1'b1;
      end
      if (x_sample_i > left_thr_q) begin
        code[BitLeft] = 1'b1;
      end else if (x_sample_i < right_thr_q) begin
        code[BitRight] = 1'b1;
      end
      code[BitBtn] = button_i;
    end
  end

  // Debounce and append decision
  assign differ   = !full && (code != last_rd_q);
  assign evaluate = !differ;  // a changed code ends the beat early
  assign accept   = (stable_q >= deb_lim_q);
  assign append   = !full && !differ && accept && (code != '0) && (code != newest_q);
  assign neutral  = (code == '0);

  always_comb begin
    idle_next = idle_q;
    if (append) begin
      idle_next = '0;
    end else if (evaluate && neutral) begin
      idle_next = idle_q + IdleW'(1);
    end
  end

  assign status_o.timeout   = evaluate && (idle_next > idle_lim_q);
  assign status_o.has_moves = (count_q != '0);
  assign status_o.rd_last   = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);

  // State update
  always_comb begin
    count_d   = count_q;
    last_rd_d = last_rd_q;
    newest_d  = newest_q;
    stable_d  = stable_q;
    idle_d    = idle_q;
    rd_idx_d  = rd_idx_q;
    if (cmd_i.tick) begin
      if (differ) begin
        last_rd_d = code;
        stable_d  = '0;
      end else if (!full) begin
        stable_d = accept ? '0 : stable_q + DebW'(1);
      end
      if (append) begin
        count_d  = count_q + CntW'(1);
        newest_d = code;
      end
      idle_d = idle_next;
      if (status_o.timeout) begin
        idle_d   = '0;
        stable_d = '0;
        newest_d = '0;
      end
    end
    if (cmd_i.rd_advance) begin
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
    if (cmd_i.rd_finish) begin
      rd_idx_d = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      last_rd_q <= '0;
      newest_q  <= '0;
      stable_q  <= '0;
      idle_q    <= '0;
      rd_idx_q  <= '0;
    end else begin
      count_q   <= count_d;
      last_rd_q <= last_rd_d;
      newest_q  <= newest_d;
      stable_q  <= stable_d;
      idle_q    <= idle_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // Move store: appended at the count, read back in order
  jgr_ram #(
    .Width (CodeW),
    .Depth (MaxMoves)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tick && append),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (code),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (move_code_o)
  );

  assign last_move_o = status_o.rd_last;

endmodule

// ----- design/jgr_ctrl.sv -----
// ============================================================================
// jgr_ctrl
// Controller: takes input beats while idle and walks the move store out,
// one result beat per store read, after a gesture timeout.
// ============================================================================
module jgr_ctrl import jgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  jgr_status_t status_i,
  output jgr_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.tick = in_valid_i;
        if (in_valid_i && status_i.timeout && status_i.has_moves) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.rd_last) begin
            cmd_o.rd_finish = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.rd_advance = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/joystick_gesture_recorder.sv -----
// ============================================================================
// joystick_gesture_recorder
// Classifies stick samples into direction codes, debounces them, records
// distinct moves and emits the recorded gesture after an idle timeout.
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid/s_axis_tready    tdata: x, y, button
//   m_axis    out   m_axis_tvalid/m_axis_tready    tdata: move code, tlast
//   cfg       in    cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// An input beat is taken while the controller is idle; beats may follow back to back.
// A timeout with stored moves stalls the input until the gesture is read out, plus
// output backpressure: each move takes a store read state, then a send state.
// Reset restores register defaults and empties the gesture; no clear pass.
// Configuration writes are accepted in every cycle.
// ============================================================================
module joystick_gesture_recorder import jgr_pkg::*; #(
  parameter int unsigned MaxMoves = MaxMovesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // samples in; tdata: [11:0] x_sample, [23:12] y_sample, [24] button_pressed
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // moves out; tdata: [4:0] move_code; tlast: last_move
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  jgr_cmd_t         cmd;
  jgr_status_t      status;
  logic [CodeW-1:0] move_code;

  assign cfg_ready_o = 1'b1;

  jgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  jgr_datapath #(
    .MaxMoves (MaxMoves)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .x_sample_i  (s_axis_tdata[SampleW-1:0]),
    .y_sample_i  (s_axis_tdata[2*SampleW-1:SampleW]),
    .button_i    (s_axis_tdata[2*SampleW]),
    .cmd_i       (cmd),
    .status_o    (status),
    .move_code_o (move_code),
    .last_move_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'(move_code);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the joystick gesture recorder. Stick samples are
// streamed in, a local model of the classifier, debouncer and move store
// predicts every move beat, and the output stream is compared beat by beat.
// A short scripted pass covers the corner samples and each direction bit.
// Register phases with random moves follow: full store, zero and maximum
// idle limits, threshold extremes and a long debounce.
// ============================================================================
module tb_top import jgr_pkg::*; ();

  localparam int unsigned MaxMoves   = MaxMovesDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned ScriptLen  = 26;

  // direction code bits
  localparam logic [CodeW-1:0] MvUp    = CodeW'(1 << BitUp);
  localparam logic [CodeW-1:0] MvDown  = CodeW'(1 << BitDown);
  localparam logic [CodeW-1:0] MvLeft  = CodeW'(1 << BitLeft);
  localparam logic [CodeW-1:0] MvRight = CodeW'(1 << BitRight);
  localparam logic [CodeW-1:0] MvBtn   = CodeW'(1 << BitBtn);
  localparam logic [CodeW-1:0] MvNone  = '0;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(7);

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last;
  } move_t;

  // scripted sample; a typed row carries its own expectation
  typedef struct packed {
    logic [SampleW-1:0] x;
    logic [SampleW-1:0] y;
    logic               b;
    logic               typed;
    logic               has_move;
    logic [CodeW-1:0]   code;
  } script_row_t;

  localparam script_row_t Script [ScriptLen] = '{
    // neutral right after reset, then a timeout with an empty store
    '{12'd2000, 12'd2000, 1'b0, 1'b1, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b1, 1'b0, MvNone},
    // lowest samples with button: one move, read out alone
    '{12'd0,    12'd0,    1'b1, 1'b1, 1'b0, MvNone},
    '{12'd999,  12'd999,  1'b1, 1'b1, 1'b0, MvNone},
    '{12'd3000, 12'd3000, 1'b0, 1'b1, 1'b0, MvNone},
    '{12'd1000, 12'd1000, 1'b0, 1'b1, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b1, 1'b1, MvUp | MvRight | MvBtn},
    // several moves, one repeated (not stored twice)
    '{12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd3001, 12'd3001, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0, MvNone},
    '{12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0, MvNone},
    '{12'd0,    12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd999,  12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd999,  12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd0,    1'b1, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd0,    1'b1, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    // button alone, then down alone
    '{12'd2000, 12'd2000, 1'b1, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b1, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd4095, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd4095, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone},
    '{12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, MvNone}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  joystick_gesture_recorder #(.MaxMoves(MaxMoves)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow registers
  logic [SampleW-1:0] thr_up    = UpThrReset;
  logic [SampleW-1:0] thr_down  = DownThrReset;
  logic [SampleW-1:0] thr_left  = LeftThrReset;
  logic [SampleW-1:0] thr_right = RightThrReset;
  logic [DebW-1:0]    deb_lim   = DebLimReset;
  logic [IdleW-1:0]   idle_lim  = IdleLimReset;

  // gesture state of the local model
  logic [CodeW-1:0]   move_log [MaxMoves];
  int unsigned        stored_n = 0;
  logic [CodeW-1:0]   prev_code = '0;
  logic [DebW-1:0]    settle_cnt = '0;
  logic [IdleW-1:0]   quiet_ticks = '0;

  move_t       fresh_moves[$];     // moves released by the latest tick
  move_t       expected_moves[$];  // moves still owed by the block
  move_t       head_move;
  int unsigned err_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_idling = 1'b0;
  bit          long_hold_done = 1'b0;

  initial begin
    for (int i = 0; i < MaxMoves; i++) move_log[i] = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40)
      $display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic logic [1:0] y_dir(input logic [SampleW-1:0] y);  // {down, up}
    if (y < thr_up) return 2'b01;
    if (y > thr_down) return 2'b10;
    return 2'b00;
  endfunction

  function automatic logic [1:0] x_dir(input logic [SampleW-1:0] x);  // {right, left}
    if (x > thr_left) return 2'b01;
    if (x < thr_right) return 2'b10;
    return 2'b00;
  endfunction

  // one tick through classifier, debouncer, store and idle timer
  task automatic predict_tick(input logic [SampleW-1:0] x, input logic [SampleW-1:0] y,
                              input logic b);
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] newest;
    bit               latched;
    int unsigned      i;
    code = '0;
    latched = 1'b0;
    fresh_moves.delete();
    if (stored_n < MaxMoves) begin
      code = {b, x_dir(x), y_dir(y)};
      if (code != prev_code) begin
        prev_code = code;
        settle_cnt = '0;
        latched = 1'b1;
      end else if (settle_cnt >= deb_lim) begin
        settle_cnt = '0;
        newest = (stored_n != 0) ? move_log[stored_n - 1] : move_log[0];
        if (code != MvNone && code != newest) begin
          move_log[stored_n] = code;
          stored_n++;
          quiet_ticks = '0;
        end
      end else begin
        settle_cnt = settle_cnt + 1'b1;
      end
    end
    if (!latched) begin
      if (code == MvNone) quiet_ticks = quiet_ticks + 1'b1;
      // timeout: read out the gesture, keep the last reading
      if (quiet_ticks > idle_lim) begin
        for (i = 0; i < stored_n; i++)
          fresh_moves.push_back('{move_log[i], (i + 1 == stored_n)});
        for (i = 0; i < MaxMoves; i++) move_log[i] = '0;
        stored_n = 0;
        quiet_ticks = '0;
        settle_cnt = '0;
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_UP_THR:    thr_up    = val[SampleW-1:0];
      CFG_DOWN_THR:  thr_down  = val[SampleW-1:0];
      CFG_LEFT_THR:  thr_left  = val[SampleW-1:0];
      CFG_RIGHT_THR: thr_right = val[SampleW-1:0];
      CFG_DEB_LIM:   deb_lim   = val[DebW-1:0];
      CFG_IDLE_LIM:  idle_lim  = val[IdleW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input beat; typed rows replace the model's moves with their own
  task automatic send_sample(input logic [SampleW-1:0] x, input logic [SampleW-1:0] y,
                             input logic b, input logic typed, input logic has_move,
                             input logic [CodeW-1:0] code);
    if (!no_idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 2 * SampleW - 1){1'b0}}, b, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    predict_tick(x, y, b);
    if (typed) begin
      if (has_move) expected_moves.push_back('{code, 1'b1});
    end else begin
      foreach (fresh_moves[i]) expected_moves.push_back(fresh_moves[i]);
    end
  endtask

  // sample biased toward the two thresholds of one axis
  function automatic logic [SampleW-1:0] sample_near(input logic [SampleW-1:0] lo,
                                                     input logic [SampleW-1:0] hi);
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 4095);
      1:       v = int'(lo) - int'($urandom_range(0, 64));
      2:       v = int'(hi) + int'($urandom_range(0, 64));
      default: v = int'(lo) + int'($urandom_range(0, 64));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SampleW-1:0];
  endfunction

  // samples that classify as the wanted code, best effort under odd thresholds
  task automatic pick_sample(input logic [CodeW-1:0] want, output logic [SampleW-1:0] x,
                             output logic [SampleW-1:0] y, output logic b);
    int unsigned tries;
    y = sample_near(thr_up, thr_down);
    for (tries = 0; tries < 40 && y_dir(y) != want[1:0]; tries++)
      y = sample_near(thr_up, thr_down);
    x = sample_near(thr_right, thr_left);
    for (tries = 0; tries < 40 && x_dir(x) != want[3:2]; tries++)
      x = sample_near(thr_right, thr_left);
    b = want[BitBtn];
  endtask

  task automatic hold_code(input logic [CodeW-1:0] want, input int unsigned ticks);
    logic [SampleW-1:0] x;
    logic [SampleW-1:0] y;
    logic               b;
    repeat (ticks) begin
      pick_sample(want, x, y, b);
      send_sample(x, y, b, 1'b0, 1'b0, MvNone);
    end
  endtask

  task automatic send_noise(input int unsigned ticks);
    repeat (ticks)
      send_sample(SampleW'($urandom_range(0, 4095)), SampleW'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0, MvNone);
  endtask

  function automatic logic [CodeW-1:0] random_move();
    logic [CodeW-1:0] mv;
    logic [1:0]       xs;
    logic [1:0]       ys;
    do begin
      xs = 2'($urandom_range(0, 2));
      ys = 2'($urandom_range(0, 2));
      mv = {1'($urandom_range(0, 1)), xs, ys};
    end while (mv == MvNone);
    return mv;
  endfunction

  // gestures of random moves; some holds too short, some noise
  task automatic run_gestures(input int unsigned min_items, input int unsigned max_moves);
    int unsigned start;
    int unsigned pad;
    logic [CodeW-1:0] mv;
    start = beats_sent;
    while (beats_sent - start < min_items) begin
      repeat ($urandom_range(0, max_moves)) begin
        mv = random_move();
        case ($urandom_range(0, 7))
          0:       send_noise($urandom_range(1, 3));
          1:       hold_code(mv, $urandom_range(1, int'(deb_lim) + 1));
          default: hold_code(mv, int'(deb_lim) + 2 + $urandom_range(0, 2));
        endcase
      end
      pad = (idle_lim > 40) ? 4 : int'(idle_lim) + 2 + $urandom_range(0, 2);
      hold_code(MvNone, pad);
    end
  endtask

  // more distinct moves than the store holds, then noise that counts as idle
  task automatic run_full_store();
    logic [CodeW-1:0] mv;
    logic [CodeW-1:0] last_mv;
    last_mv = prev_code;
    repeat (MaxMoves + 3) begin
      do mv = random_move(); while (mv == last_mv);
      hold_code(mv, int'(deb_lim) + 2);
      last_mv = mv;
    end
    send_noise(int'(idle_lim) + 3);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic randomize_regs();
    logic [3:0]         junk4;
    logic [DebW-1:0]    junk8;
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] hi;
    junk4 = 4'($urandom);
    lo = SampleW'($urandom_range(200, 1800));
    hi = lo + SampleW'($urandom_range(200, 2000));
    write_reg(CFG_UP_THR, {junk4, lo});
    write_reg(CFG_DOWN_THR, {4'd0, hi});
    junk4 = 4'($urandom);
    lo = SampleW'($urandom_range(200, 1800));
    hi = lo + SampleW'($urandom_range(200, 2000));
    write_reg(CFG_RIGHT_THR, {4'd0, lo});
    write_reg(CFG_LEFT_THR, {junk4, hi});
    junk8 = DebW'($urandom);
    write_reg(CFG_DEB_LIM, {junk8, DebW'($urandom_range(0, 3))});
    write_reg(CFG_IDLE_LIM, IdleW'($urandom_range(1, 8)));
  endtask

  // move beat checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_moves.size() == 0) begin
        report_mismatch("move beat with none pending", m_axis_tdata, 0);
      end else begin
        head_move = expected_moves.pop_front();
        if (m_axis_tdata[CodeW-1:0] != head_move.code)
          report_mismatch("move_code", m_axis_tdata[CodeW-1:0], head_move.code);
        if (m_axis_tdata[OutDataW-1:CodeW] != '0)
          report_mismatch("tdata padding", m_axis_tdata[OutDataW-1:CodeW], 0);
        if (m_axis_tlast != head_move.last)
          report_mismatch("last_move", m_axis_tlast, head_move.last);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off that backs up the input
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && beats_sent >= 60 && m_axis_tvalid === 1'b1) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!no_idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scripted pass: immediate accept, short idle limit, reset thresholds
    write_reg(CFG_DEB_LIM, CfgW'(0));
    write_reg(CFG_IDLE_LIM, CfgW'(1));
    for (int i = 0; i < ScriptLen; i++)
      send_sample(Script[i].x, Script[i].y, Script[i].b, Script[i].typed,
                  Script[i].has_move, Script[i].code);
    drain();

    // random thresholds, short debounce
    repeat (2) begin
      randomize_regs();
      run_gestures(40, 5);
      drain();
    end

    // store overflow; readout keeps the last reading
    write_reg(CFG_DEB_LIM, CfgW'(0));
    write_reg(CFG_IDLE_LIM, CfgW'(3));
    run_full_store();
    run_gestures(10, 3);
    drain();

    // zero idle limit
    write_reg(CFG_DEB_LIM, CfgW'(1));
    write_reg(CFG_IDLE_LIM, CfgW'(0));
    run_gestures(25, 3);
    drain();

    // thresholds that make every axis neutral
    write_reg(CFG_UP_THR, CfgW'(0));
    write_reg(CFG_DOWN_THR, CfgW'(4095));
    write_reg(CFG_LEFT_THR, CfgW'(4095));
    write_reg(CFG_RIGHT_THR, CfgW'(0));
    write_reg(CFG_IDLE_LIM, CfgW'(2));
    run_gestures(20, 3);
    drain();

    // thresholds at the opposite ends
    write_reg(CFG_UP_THR, CfgW'(4095));
    write_reg(CFG_DOWN_THR, CfgW'(0));
    write_reg(CFG_LEFT_THR, CfgW'(0));
    write_reg(CFG_RIGHT_THR, CfgW'(4095));
    run_gestures(20, 3);
    drain();

    // largest idle limit never times out; then a small one flushes the store
    randomize_regs();
    write_reg(CFG_IDLE_LIM, CfgW'(16'hFFFF));
    run_gestures(20, 4);
    drain();
    write_reg(CFG_IDLE_LIM, CfgW'(1));
    hold_code(MvNone, 4);
    drain();

    // long debounce: at most one held move per gesture
    write_reg(CFG_DEB_LIM, CfgW'(20));
    write_reg(CFG_IDLE_LIM, CfgW'(2));
    run_gestures(30, 1);
    drain();

    // writes to unused indexes must change nothing
    write_reg(CfgSpareLo, CfgW'($urandom));
    write_reg(CfgSpareHi, CfgW'($urandom));

    // closing stretch at full rate
    no_idling = 1'b1;
    randomize_regs();
    run_gestures(40, 5);
    drain();

    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
